/* sv/sse_pkg.sv */
package sse_pkg;

    // Word widths of the Q16.16 datapath
    localparam int Q_W      = 32;
    localparam int ROW_W    = 64;
    localparam int PROD_W   = 64;
    localparam int RQ_W     = 48;   // rounded product, PROD_W - 16
    localparam int MAX_DIM  = 2;

    // Model dimensions
    localparam int STATES_DEF = 2;
    localparam int INPUTS_DEF = 2;
    localparam int OUTPUTS    = 1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_A_ROW_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A_ROW_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B_ROW_FIRST  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B_ROW_SECOND = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_C_ROW        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_D_ROW        = 3'd5;

    localparam logic signed [PROD_W-1:0] ROUND_HALF = 64'sd32768;
    localparam logic signed [63:0] Q_MAX_64 = 64'sd2147483647;
    localparam logic signed [63:0] Q_MIN_64 = -64'sd2147483648;

    typedef struct packed {
        logic signed [Q_W-1:0] drive_first;
        logic signed [Q_W-1:0] drive_second;
        logic        [Q_W-1:0] time_step;
    } drive_item_t;

    typedef struct packed {
        logic signed [Q_W-1:0] model_output;
        logic signed [Q_W-1:0] next_state_first;
        logic signed [Q_W-1:0] next_state_second;
        logic                  saturated;
    } result_item_t;

    typedef struct packed {
        logic clear;    // start of item: zero the accumulator
        logic issue;    // multiply the selected term
        logic finish;   // clip and hold the row sum
    } lane_ctrl_t;

    typedef struct packed {
        logic mul;      // form xdot * dt
        logic upd;      // round, add to the state and clip
    } merge_ctrl_t;

    typedef struct packed {
        logic                  sat;
        logic signed [Q_W-1:0] value;
    } clip_t;

    // Add one half LSB of Q16.16 and drop sixteen bits with floor
    function automatic logic signed [RQ_W-1:0] round_q(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = p + ROUND_HALF;
        return $signed(t[PROD_W-1:16]);
    endfunction

    // Clip to the signed 32-bit range and flag it
    function automatic clip_t sat32(input logic signed [63:0] v);
        clip_t r;
        if (v > Q_MAX_64)
        begin
            r.sat   = 1'b1;
            r.value = Q_MAX_64[Q_W-1:0];
        end
        else if (v < Q_MIN_64)
        begin
            r.sat   = 1'b1;
            r.value = Q_MIN_64[Q_W-1:0];
        end
        else
        begin
            r.sat   = 1'b0;
            r.value = v[Q_W-1:0];
        end
        return r;
    endfunction

endpackage

/* sv/sse_if.sv */
interface sse_drive_if;
    import sse_pkg::*;
    logic        valid;
    logic        ready;
    drive_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sse_result_if;
    import sse_pkg::*;
    logic         valid;
    logic         ready;
    result_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sse_cfg_if;
    import sse_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [ROW_W-1:0]     value;
    modport source (output valid, output index, output value, input ready);
    modport sink   (input valid, input index, input value, output ready);
endinterface

/* sv/state_space_euler_step.sv */
// Channel  | Role   | Payload
// ---------+--------+-----------------------------------------------------
// cfg      | sink   | index, value: one 64-bit matrix row per write
// drive    | sink   | drive_first, drive_second, time_step
// result   | source | model_output, next_state_first, next_state_second,
//          |        | saturated
//
// Between one acceptance and the next, each lane's single multiplier walks
// its terms, then come clipping, the dt multiply and the state update.
// The result sits in an output register; a new item is taken while it waits.
// If the previous result is still held, the finished item waits in place.
// Reset clears the matrices, the state and all handshake control.
// cfg is always ready; writes are expected only while the block is idle.
module state_space_euler_step #(
    parameter int STATES = sse_pkg::STATES_DEF,
    parameter int INPUTS = sse_pkg::INPUTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    sse_cfg_if.sink             cfg,
    sse_drive_if.sink           drive,
    sse_result_if.source        result
);
    import sse_pkg::*;

    localparam int TERMS  = STATES + INPUTS;
    localparam int TERM_W = $clog2(TERMS);
    localparam int LANES  = STATES + OUTPUTS;

    // Sequencer phases
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_DOT   = 3'd1;
    localparam logic [2:0] PH_DRAIN = 3'd2;
    localparam logic [2:0] PH_CLIP  = 3'd3;
    localparam logic [2:0] PH_MUL   = 3'd4;
    localparam logic [2:0] PH_UPD   = 3'd5;
    localparam logic [2:0] PH_DONE  = 3'd6;

    logic [2:0]        phase_reg;
    logic [2:0]        phase_next;
    logic [TERM_W-1:0] term_reg;
    logic [TERM_W-1:0] term_next;

    // Matrix rows, written through the configuration channel
    logic [ROW_W-1:0] a_row_reg [MAX_DIM];
    logic [ROW_W-1:0] b_row_reg [MAX_DIM];
    logic [ROW_W-1:0] c_row_reg;
    logic [ROW_W-1:0] d_row_reg;

    // Model state and the latched item
    logic signed [Q_W-1:0] x_reg  [STATES];
    logic signed [Q_W-1:0] u_reg  [INPUTS];
    logic        [Q_W-1:0] dt_reg;

    logic signed [Q_W-1:0] lane_sum  [LANES];
    logic [LANES-1:0]      lane_sat;
    logic signed [Q_W-1:0] xdot      [STATES];
    logic signed [Q_W-1:0] x_upd     [STATES];
    logic                  step_sat;

    logic          out_valid_reg;
    result_item_t  out_data_reg;
    result_item_t  out_data_next;

    logic          accept;
    logic          load_out;
    lane_ctrl_t    lane_ctrl;
    merge_ctrl_t   merge_ctrl;

    assign cfg.ready   = 1'b1;
    assign drive.ready = (phase_reg == PH_IDLE);
    assign accept      = drive.valid & drive.ready;
    assign load_out    = (phase_reg == PH_DONE) & (~out_valid_reg | result.ready);

    // ---------------------------------------------------------------
    // Configuration writes; unknown indexes drop silently
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_row_reg[0] <= '0;
            a_row_reg[1] <= '0;
            b_row_reg[0] <= '0;
            b_row_reg[1] <= '0;
            c_row_reg    <= '0;
            d_row_reg    <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_A_ROW_FIRST:  a_row_reg[0] <= cfg.value;
                REG_A_ROW_SECOND: a_row_reg[1] <= cfg.value;
                REG_B_ROW_FIRST:  b_row_reg[0] <= cfg.value;
                REG_B_ROW_SECOND: b_row_reg[1] <= cfg.value;
                REG_C_ROW:        c_row_reg    <= cfg.value;
                REG_D_ROW:        d_row_reg    <= cfg.value;
                default:          ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Sequencer: walk the terms, then clip, multiply by dt, update
    // ---------------------------------------------------------------
    always_comb
    begin
        phase_next = phase_reg;
        term_next  = term_reg;
        lane_ctrl  = '0;
        merge_ctrl = '0;
        case (phase_reg)
            PH_IDLE:
            begin
                lane_ctrl.clear = accept;
                if (accept)
                begin
                    phase_next = PH_DOT;
                    term_next  = '0;
                end
            end
            PH_DOT:
            begin
                lane_ctrl.issue = 1'b1;
                if (term_reg == TERM_W'(TERMS - 1))
                begin
                    phase_next = PH_DRAIN;
                end
                else
                begin
                    term_next = term_reg + TERM_W'(1);
                end
            end
            PH_DRAIN: phase_next = PH_CLIP;
            PH_CLIP:
            begin
                lane_ctrl.finish = 1'b1;
                phase_next       = PH_MUL;
            end
            PH_MUL:
            begin
                merge_ctrl.mul = 1'b1;
                phase_next     = PH_UPD;
            end
            PH_UPD:
            begin
                merge_ctrl.upd = 1'b1;
                phase_next     = PH_DONE;
            end
            PH_DONE:
            begin
                // Hold until the output register is free
                if (load_out)
                begin
                    phase_next = PH_IDLE;
                end
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            term_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            term_reg  <= term_next;
        end
    end

    // Latch the item payload on acceptance
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int j = 0; j < INPUTS; j++)
            begin
                u_reg[j] <= (j == 0) ? drive.data.drive_first : drive.data.drive_second;
            end
            dt_reg <= drive.data.time_step;
        end
    end

    // ---------------------------------------------------------------
    // Lanes: one per state row of A/B, one for the C/D output row
    // ---------------------------------------------------------------
    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        logic [ROW_W-1:0] xrow;
        logic [ROW_W-1:0] urow;
        if (l < STATES)
        begin : g_state_row
            assign xrow = a_row_reg[l];
            assign urow = b_row_reg[l];
            assign xdot[l] = lane_sum[l];
        end
        else
        begin : g_out_row
            assign xrow = c_row_reg;
            assign urow = d_row_reg;
        end

        sse_dot_lane #(
            .STATES (STATES),
            .INPUTS (INPUTS),
            .TERM_W (TERM_W)
        ) u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (lane_ctrl),
            .term  (term_reg),
            .xrow  (xrow),
            .urow  (urow),
            .state (x_reg),
            .drive (u_reg),
            .sum   (lane_sum[l]),
            .sat   (lane_sat[l])
        );
    end

    sse_merge #(
        .STATES (STATES)
    ) u_merge (
        .clk      (clk),
        .ctrl     (merge_ctrl),
        .xdot     (xdot),
        .lane_sat (lane_sat),
        .dt       (dt_reg),
        .state    (x_reg),
        .next     (x_upd),
        .sat      (step_sat)
    );

    // ---------------------------------------------------------------
    // Result register and state commit
    // ---------------------------------------------------------------
    always_comb
    begin
        out_data_next.model_output      = lane_sum[STATES];
        out_data_next.next_state_first  = x_upd[0];
        out_data_next.next_state_second = (STATES > 1) ? x_upd[STATES-1] : '0;
        out_data_next.saturated         = step_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < STATES; i++)
            begin
                x_reg[i] <= '0;
            end
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                x_reg         <= x_upd;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

endmodule

/* sv/sse_dot_lane.sv */
// One dot-product lane: walks the state terms then the drive terms through a
// single registered multiplier, accumulates rounded products, clips once.
module sse_dot_lane #(
    parameter int STATES = sse_pkg::STATES_DEF,
    parameter int INPUTS = sse_pkg::INPUTS_DEF,
    parameter int TERM_W = 2
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  sse_pkg::lane_ctrl_t              ctrl,
    input  logic [TERM_W-1:0]                term,
    input  logic [sse_pkg::ROW_W-1:0]        xrow,
    input  logic [sse_pkg::ROW_W-1:0]        urow,
    input  logic signed [sse_pkg::Q_W-1:0]   state [STATES],
    input  logic signed [sse_pkg::Q_W-1:0]   drive [INPUTS],
    output logic signed [sse_pkg::Q_W-1:0]   sum,
    output logic                             sat
);
    import sse_pkg::*;

    localparam int TERMS = STATES + INPUTS;
    localparam int ACC_W = RQ_W + $clog2(TERMS);

    logic signed [Q_W-1:0]    coef_sel;
    logic signed [Q_W-1:0]    op_sel;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_vld_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [RQ_W-1:0]   prod_rnd;
    logic signed [Q_W-1:0]    sum_reg;
    logic                     sat_reg;
    clip_t                    acc_clip;

    // Select coefficient and operand for the current term
    always_comb
    begin
        coef_sel = '0;
        op_sel   = '0;
        for (int j = 0; j < STATES; j++)
        begin
            if (term == TERM_W'(j))
            begin
                coef_sel = $signed(xrow[Q_W*j +: Q_W]);
                op_sel   = state[j];
            end
        end
        for (int j = 0; j < INPUTS; j++)
        begin
            if (term == TERM_W'(STATES + j))
            begin
                coef_sel = $signed(urow[Q_W*j +: Q_W]);
                op_sel   = drive[j];
            end
        end
    end

    assign prod_rnd = round_q(prod_reg);
    assign acc_clip = sat32({{(64-ACC_W){acc_reg[ACC_W-1]}}, acc_reg});

    always_ff @(posedge clk)
    begin
        if (ctrl.issue)
        begin
            prod_reg <= PROD_W'(coef_sel) * PROD_W'(op_sel);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            prod_vld_reg <= ctrl.issue;
            if (ctrl.clear)
            begin
                acc_reg <= '0;
            end
            else if (prod_vld_reg)
            begin
                acc_reg <= acc_reg + ACC_W'(prod_rnd);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.finish)
        begin
            sum_reg <= acc_clip.value;
            sat_reg <= acc_clip.sat;
        end
    end

    assign sum = sum_reg;
    assign sat = sat_reg;

endmodule

/* sv/sse_merge.sv */
// Merge stage: one Euler update per state element, plus the combined flag.
module sse_merge #(
    parameter int STATES = sse_pkg::STATES_DEF
) (
    input  logic                           clk,
    input  sse_pkg::merge_ctrl_t           ctrl,
    input  logic signed [sse_pkg::Q_W-1:0] xdot  [STATES],
    input  logic [STATES+sse_pkg::OUTPUTS-1:0] lane_sat,
    input  logic [sse_pkg::Q_W-1:0]        dt,
    input  logic signed [sse_pkg::Q_W-1:0] state [STATES],
    output logic signed [sse_pkg::Q_W-1:0] next  [STATES],
    output logic                           sat
);
    import sse_pkg::*;

    logic signed [PROD_W-1:0] mul_full [STATES];
    logic signed [PROD_W-1:0] prod_reg [STATES];
    logic signed [RQ_W-1:0]   inc      [STATES];
    logic signed [63:0]       upd_sum  [STATES];
    clip_t                    upd_clip [STATES];
    logic signed [Q_W-1:0]    next_reg [STATES];
    logic                     clip_any;
    logic                     sat_reg;

    always_comb
    begin
        clip_any = 1'b0;
        for (int i = 0; i < STATES; i++)
        begin
            // xdot is signed 32 bits and dt unsigned 32 bits: the product fits in 64
            mul_full[i] = PROD_W'(xdot[i]) * PROD_W'($signed({1'b0, dt}));
            inc[i]      = round_q(prod_reg[i]);
            upd_sum[i]  = {{(64-Q_W){state[i][Q_W-1]}}, state[i]}
                        + {{(64-RQ_W){inc[i][RQ_W-1]}}, inc[i]};
            upd_clip[i] = sat32(upd_sum[i]);
            clip_any    = clip_any | upd_clip[i].sat;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < STATES; i++)
        begin
            if (ctrl.mul)
            begin
                prod_reg[i] <= mul_full[i];
            end
            if (ctrl.upd)
            begin
                next_reg[i] <= upd_clip[i].value;
            end
        end
        if (ctrl.upd)
        begin
            sat_reg <= (|lane_sat) | clip_any;
        end
    end

    assign next = next_reg;
    assign sat  = sat_reg;

endmodule
